/* sv/stq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// Pool size, link encoding, operation and status codes.
// ---------------------------------------------------------------------------
package stq_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LINK_W   = $clog2(CAPACITY + 1);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

   typedef logic [1:0]        func_type;
   typedef logic [2:0]        status_type;
   typedef logic [LINK_W-1:0] link_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_POP    = 2'd1;
   localparam func_type FUNC_REMOVE = 2'd2;

   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_POPPED    = 3'd1;
   localparam status_type ST_NOT_DUE   = 3'd2;
   localparam status_type ST_FULL      = 3'd3;
   localparam status_type ST_REMOVED   = 3'd4;
   localparam status_type ST_NOT_FOUND = 3'd5;

endpackage

/* sv/sorted_timer_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_timer_queue: deadline-sorted timer pool
// Linked list of timer entries kept in deadline order, plus a free list.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the single result strobes on rsp_valid for one cycle, and the
// receiver cannot stall it. A sequencer reads one linked entry at a time
// from the slot memories (registered read port) through S_RD, S_WAIT and
// S_EVAL: pop reads only the head, while insert and remove walk past k
// entries, k being at most CAPACITY, 32.
// The single compare/link-update path is shared by every step. No clearing
// pass is needed after reset: the free chain is generated by a fill count
// until every slot has been used once.
// ---------------------------------------------------------------------------
module sorted_timer_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  stq_pkg::func_type           req_func,
   input  logic [63:0]                 req_time_value,
   input  logic signed [31:0]          req_user_param,
   input  logic [31:0]                 req_user_ref,
   input  logic [31:0]                 req_target_handle,
   output logic                        rsp_valid,
   output stq_pkg::status_type         rsp_status,
   output logic [31:0]                 rsp_out_handle,
   output logic signed [31:0]          rsp_out_param,
   output logic [31:0]                 rsp_out_ref,
   output logic [stq_pkg::CNT_W-1:0]   rsp_entry_count
);
   import stq_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DISP   = 10'b0000000010,
      S_RD     = 10'b0000000100,
      S_WAIT   = 10'b0000001000,
      S_EVAL   = 10'b0000010000,
      S_FIXA   = 10'b0000100000,
      S_FIXB   = 10'b0001000000,
      S_FREE   = 10'b0010000000,
      S_FNEXT  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   // slot memories, one write and one registered read port each
   logic [63:0]      dl_mem  [CAPACITY];
   logic [31:0]      par_mem [CAPACITY];
   logic [31:0]      ref_mem [CAPACITY];
   logic [31:0]      hdl_mem [CAPACITY];
   link_type         nxt_mem [CAPACITY];
   link_type         prv_mem [CAPACITY];

   logic [63:0]      rd_dl;
   logic [31:0]      rd_par, rd_ref, rd_hdl;
   link_type         rd_nxt, rd_prv;

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   logic [63:0]      time_ff, time_in;
   logic [31:0]      param_ff, param_in, uref_ff, uref_in, target_ff, target_in;
   link_type         head_ff, head_in, free_ff, free_in;
   logic [CNT_W-1:0] count_ff, count_in, fill_ff, fill_in;
   logic [31:0]      hctr_ff, hctr_in;
   link_type         cur_ff, cur_in, last_ff, last_in, pos_ff, pos_in;
   link_type         lnk_a_ff, lnk_a_in, lnk_b_ff, lnk_b_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   status_type       st_ff, st_in;
   logic [31:0]      oh_ff, oh_in, op_ff, op_in, or_ff, or_in;

   // memory control
   logic [IDX_W-1:0] rd_addr;
   logic             wr_data_en;
   logic [IDX_W-1:0] wr_data_addr;
   logic             wr_nxt_en, wr_prv_en;
   logic [IDX_W-1:0] wr_nxt_addr, wr_prv_addr;
   link_type         wr_nxt_val, wr_prv_val;

   function automatic logic is_slot(link_type l);
      return l < NIL_LINK;
   endfunction

   // slot memory ports
   always_ff @(posedge clock) begin
      if (wr_data_en) begin
         dl_mem[wr_data_addr]  <= time_ff;
         par_mem[wr_data_addr] <= param_ff;
         ref_mem[wr_data_addr] <= uref_ff;
         hdl_mem[wr_data_addr] <= hctr_ff;
      end
      if (wr_nxt_en) begin
         nxt_mem[wr_nxt_addr] <= wr_nxt_val;
      end
      if (wr_prv_en) begin
         prv_mem[wr_prv_addr] <= wr_prv_val;
      end
      rd_dl  <= dl_mem[rd_addr];
      rd_par <= par_mem[rd_addr];
      rd_ref <= ref_mem[rd_addr];
      rd_hdl <= hdl_mem[rd_addr];
      rd_nxt <= nxt_mem[rd_addr];
      rd_prv <= prv_mem[rd_addr];
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL_LINK;
         free_ff  <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
         hctr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         hctr_ff  <= hctr_in;
      end
      func_ff  <= func_in;
      time_ff  <= time_in;
      param_ff <= param_in;
      uref_ff  <= uref_in;
      target_ff <= target_in;
      cur_ff   <= cur_in;
      last_ff  <= last_in;
      pos_ff   <= pos_in;
      lnk_a_ff <= lnk_a_in;
      lnk_b_ff <= lnk_b_in;
      steps_ff <= steps_in;
      st_ff    <= st_in;
      oh_ff    <= oh_in;
      op_ff    <= op_in;
      or_ff    <= or_in;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      time_in   = time_ff;
      param_in  = param_ff;
      uref_in   = uref_ff;
      target_in = target_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      hctr_in   = hctr_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      pos_in    = pos_ff;
      lnk_a_in  = lnk_a_ff;
      lnk_b_in  = lnk_b_ff;
      steps_in  = steps_ff;
      st_in     = st_ff;
      oh_in     = oh_ff;
      op_in     = op_ff;
      or_in     = or_ff;
      rd_addr      = cur_ff[IDX_W-1:0];
      wr_data_en   = 1'b0;
      wr_data_addr = pos_ff[IDX_W-1:0];
      wr_nxt_en    = 1'b0;
      wr_prv_en    = 1'b0;
      wr_nxt_addr  = '0;
      wr_prv_addr  = '0;
      wr_nxt_val   = NIL_LINK;
      wr_prv_val   = NIL_LINK;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = req_func;
               time_in   = req_time_value;
               param_in  = req_user_param;
               uref_in   = req_user_ref;
               target_in = req_target_handle;
               st_in     = ST_NOT_DUE;
               oh_in     = '0;
               op_in     = '0;
               or_in     = '0;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            cur_in   = head_ff;
            last_in  = NIL_LINK;
            steps_in = '0;
            state_in = S_DONE;
            case (func_ff)
               FUNC_INSERT: begin
                  if (!is_slot(free_ff)) begin
                     st_in = ST_FULL;
                  end else begin
                     // take the free slot and store the payload
                     pos_in     = free_ff;
                     wr_data_en = 1'b1;
                     wr_data_addr = free_ff[IDX_W-1:0];
                     oh_in      = hctr_ff;
                     hctr_in    = hctr_ff + 32'd1;
                     count_in   = count_ff + 1'b1;
                     st_in      = ST_INSERTED;
                     rd_addr    = free_ff[IDX_W-1:0];
                     if (free_ff == LINK_W'(fill_ff)) begin
                        // slot never used: chain is implicit
                        fill_in = fill_ff + 1'b1;
                        free_in = LINK_W'(fill_ff) + 1'b1;
                        state_in = S_RD;
                     end else begin
                        state_in = S_FNEXT;
                     end
                  end
               end
               FUNC_POP: begin
                  if (is_slot(head_ff)) state_in = S_RD;
               end
               FUNC_REMOVE: begin
                  st_in = ST_NOT_FOUND;
                  if (is_slot(head_ff)) state_in = S_RD;
               end
               default: ;
            endcase
         end
         S_FNEXT: begin
            // free slot's next link read back
            free_in  = rd_nxt;
            state_in = S_RD;
         end
         S_RD: begin
            // issue read of the current entry
            if (func_ff == FUNC_INSERT && !is_slot(cur_ff)) begin
               state_in = S_EVAL;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            case (func_ff)
               FUNC_INSERT: begin
                  if (is_slot(cur_ff) && steps_ff < CNT_W'(CAPACITY)
                        && rd_dl < time_ff) begin
                     last_in  = cur_ff;
                     cur_in   = rd_nxt;
                     steps_in = steps_ff + 1'b1;
                     state_in = S_RD;
                  end else begin
                     // link pos between prev and cur
                     if (is_slot(cur_ff) && steps_ff < CNT_W'(CAPACITY)) begin
                        lnk_a_in = rd_prv;
                        lnk_b_in = cur_ff;
                     end else begin
                        lnk_a_in = last_ff;
                        lnk_b_in = NIL_LINK;
                     end
                     state_in = S_FIXA;
                  end
               end
               FUNC_POP: begin
                  if (rd_dl <= time_ff) begin
                     oh_in    = rd_hdl;
                     op_in    = rd_par;
                     or_in    = rd_ref;
                     st_in    = ST_POPPED;
                     pos_in   = cur_ff;
                     lnk_a_in = rd_prv;
                     lnk_b_in = rd_nxt;
                     state_in = S_FREE;
                  end
               end
               default: begin
                  if (rd_hdl == target_ff) begin
                     st_in    = ST_REMOVED;
                     pos_in   = cur_ff;
                     lnk_a_in = rd_prv;
                     lnk_b_in = rd_nxt;
                     state_in = S_FREE;
                  end else if (is_slot(rd_nxt)
                        && steps_ff + 1'b1 < CNT_W'(CAPACITY)) begin
                     cur_in   = rd_nxt;
                     steps_in = steps_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_FIXA: begin
            // insert: pos links, then neighbour prev/next links or head
            wr_nxt_en   = 1'b1;
            wr_nxt_addr = pos_ff[IDX_W-1:0];
            wr_nxt_val  = lnk_b_ff;
            wr_prv_en   = 1'b1;
            wr_prv_addr = pos_ff[IDX_W-1:0];
            wr_prv_val  = lnk_a_ff;
            state_in    = S_FIXB;
         end
         S_FIXB: begin
            if (is_slot(lnk_b_ff)) begin
               wr_prv_en   = 1'b1;
               wr_prv_addr = lnk_b_ff[IDX_W-1:0];
               wr_prv_val  = pos_ff;
            end
            if (is_slot(lnk_a_ff)) begin
               wr_nxt_en   = 1'b1;
               wr_nxt_addr = lnk_a_ff[IDX_W-1:0];
               wr_nxt_val  = pos_ff;
            end else begin
               head_in = pos_ff;
            end
            state_in = S_DONE;
         end
         S_FREE: begin
            // unlink pos (prev=a, next=b) and push it on the free list
            if (is_slot(lnk_b_ff)) begin
               wr_prv_en   = 1'b1;
               wr_prv_addr = lnk_b_ff[IDX_W-1:0];
               wr_prv_val  = lnk_a_ff;
            end
            if (is_slot(lnk_a_ff)) begin
               // neighbours done, second pass only pushes pos
               wr_nxt_en   = 1'b1;
               wr_nxt_addr = lnk_a_ff[IDX_W-1:0];
               wr_nxt_val  = lnk_b_ff;
               lnk_a_in    = NIL_LINK;
               lnk_b_in    = NIL_LINK;
               state_in    = S_FREE;
            end else begin
               if (!is_slot(lnk_b_ff) || lnk_a_ff == NIL_LINK) begin
                  if (pos_ff == head_ff) head_in = lnk_b_ff;
               end
               wr_nxt_en   = 1'b1;
               wr_nxt_addr = pos_ff[IDX_W-1:0];
               wr_nxt_val  = free_ff;
               free_in     = pos_ff;
               count_in    = count_ff - 1'b1;
               lnk_b_in    = NIL_LINK;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_DONE;
   assign rsp_status      = st_ff;
   assign rsp_out_handle  = oh_ff;
   assign rsp_out_param   = op_ff;
   assign rsp_out_ref     = or_ff;
   assign rsp_entry_count = count_ff;

endmodule
